/* rtl/core/sorted_interval_insert_table_unit_defines.svh */
// Assertion macros for the sorted interval insertion table.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
// Both macros sample on clk_i; the first is switched off while rst_ni is low.
`ifndef SORTED_INTERVAL_INSERT_TABLE_UNIT_DEFINES_SVH
`define SORTED_INTERVAL_INSERT_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define SIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SIT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SIT_ASSERT(lbl, prop, msg)
`define SIT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/sit_pkg.sv */
// Shared types, codes and the record ordering function of the sorted interval table.
// No dependencies; imported by sit_cell, sit_or_tree and the top level.
package sit_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam int KEY_W   = 64;
  localparam int POS_W   = 6;
  localparam int COUNT_W = 7;
  localparam int IN_TAG_W = 16;
  localparam int GROUP_SIZE = 8;

  // Status of one cell as seen by its upper neighbor.
  typedef struct packed {
    logic occ;       // cell holds a record
    logic precedes;  // new record orders strictly before the held one
  } link_t;

  typedef struct packed {
    logic ins_en;  // insert step in this cycle
  } cell_ctrl_t;

  // True when record (s, e) orders strictly before record (os, oe).
  function automatic logic orders_before(logic signed [KEY_W-1:0] s,
                                         logic signed [KEY_W-1:0] e,
                                         logic signed [KEY_W-1:0] os,
                                         logic signed [KEY_W-1:0] oe);
    return (s < os) || ((s == os) && (e < oe));
  endfunction

endpackage

/* rtl/core/sorted_interval_insert_table_unit.sv */
// Top level of the sorted interval insertion table: FSM, record count, the
// row of sit_cell slots and the sit_or_tree result reduction. Uses sit_pkg and the defines header.
//
//  Channel  | Dir | tuser        | tdata (lowest bit up)
//  ---------+-----+--------------+---------------------------------------------------
//  s_axis   | in  | func         | start_time, end_time, element_tag, read_index, pad
//  m_axis   | out | status       | position, entry_count, entry_start, entry_end,
//           |     |              | entry_tag, pad
//
// Requests are taken one at a time, in steps: the idle state, in which a request is
// accepted; the execute step, in which all slots compare against the new record and shift in
// parallel while the first level of the result OR tree is registered; and the reduce step, in
// which the second level is ORed into the output register. A new request is not taken
// until the result has been loaded into the output register.
// Reset clears the record count and the control state; the slot contents are
// not cleared, because only slots below the count are ever read.
// A stalled output holds the finished result in the tree stage until the
// output register frees; the input side stays closed while the tree stage waits.
`include "sorted_interval_insert_table_unit_defines.svh"

module sorted_interval_insert_table_unit #(
  parameter int CAPACITY  = 64,
  parameter int TAG_WIDTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [0:0]   s_axis_tuser,   // func
  input  logic [151:0] s_axis_tdata,   // start_time, end_time, element_tag, read_index
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [1:0]   m_axis_tuser,   // status
  output logic [159:0] m_axis_tdata    // position, entry_count, entry_start,
                                       // entry_end, entry_tag
);
  import sit_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CW > POS_W) ? CW : POS_W;
  localparam int LW    = POS_W + 2 * KEY_W + TAG_WIDTH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RED  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;

  // Request held for the compare-and-shift cycle.
  logic                    func_q;
  logic signed [KEY_W-1:0] req_start_q;
  logic signed [KEY_W-1:0] req_end_q;
  logic [TAG_WIDTH-1:0]    req_tag_q;
  logic [POS_W-1:0]        req_idx_q;

  // Result metadata captured alongside the tree's first level.
  logic               res_func_q;
  logic [1:0]         res_status_q;
  logic [POS_W-1:0]   res_idx_q;
  logic [COUNT_W-1:0] res_count_q;

  // Output register.
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [POS_W-1:0]   out_pos_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [KEY_W-1:0]   out_start_q;
  logic [KEY_W-1:0]   out_end_q;
  logic [IN_TAG_W-1:0] out_tag_q;

  logic in_fire;
  logic out_load;
  logic full;
  logic ins_en;
  logic rd_miss;
  logic [1:0] status_d;
  sit_pkg::cell_ctrl_t cell_ctrl;

  sit_pkg::link_t                  link    [CAPACITY+1];
  logic signed [KEY_W-1:0]         c_start [CAPACITY+1];
  logic signed [KEY_W-1:0]         c_end   [CAPACITY+1];
  logic [TAG_WIDTH-1:0]            c_tag   [CAPACITY+1];
  logic [CAPACITY-1:0]             load;
  logic [CAPACITY-1:0]             sel;
  logic [CAPACITY-1:0][LW-1:0]     lane;
  logic [LW-1:0]                   tree_sum;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CW'(CAPACITY));
  assign ins_en        = (state_q == ST_EXEC) && (func_q == FUNC_INSERT) && !full;
  assign cell_ctrl     = '{ins_en: ins_en};
  assign rd_miss       = (CMP_W'(req_idx_q) >= CMP_W'(count_q));
  assign out_load      = (state_q == ST_RED) && (!out_valid_q || m_axis_tready);

  always_comb begin
    if (func_q == FUNC_INSERT) begin
      status_d = full ? STATUS_FULL : STATUS_OK;
    end else begin
      status_d = rd_miss ? STATUS_RANGE : STATUS_OK;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire)  state_d = ST_EXEC;
      ST_EXEC: state_d = ST_RED;
      ST_RED:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign count_d = ins_en ? count_q + CW'(1) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q      <= s_axis_tuser[0];
      req_start_q <= s_axis_tdata[63:0];
      req_end_q   <= s_axis_tdata[127:64];
      req_tag_q   <= TAG_WIDTH'(s_axis_tdata[143:128]);
      req_idx_q   <= s_axis_tdata[149:144];
    end
    if (state_q == ST_EXEC) begin
      res_func_q   <= func_q;
      res_status_q <= status_d;
      res_idx_q    <= req_idx_q;
      res_count_q  <= COUNT_W'(count_d);
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      // A read reports its own index even when it misses; a dropped insert
      // selects no slot and so reports zero.
      out_pos_q    <= (res_func_q == FUNC_READ) ? res_idx_q : tree_sum[LW-1 -: POS_W];
      out_count_q  <= res_count_q;
      out_start_q  <= tree_sum[2*KEY_W+TAG_WIDTH-1 -: KEY_W];
      out_end_q    <= tree_sum[KEY_W+TAG_WIDTH-1 -: KEY_W];
      out_tag_q    <= IN_TAG_W'(tree_sum[TAG_WIDTH-1:0]);
    end
  end

  // The slot below slot zero is a permanent occupied slot that the new record
  // never precedes, so slot zero needs no special case.
  assign link[0]    = '{occ: 1'b1, precedes: 1'b0};
  assign c_start[0] = '0;
  assign c_end[0]   = '0;
  assign c_tag[0]   = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic occ;
    logic rd_hit;

    assign occ = (CW'(k) < count_q);

    sit_cell #(
      .TagW (TAG_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl),
      .occ_i        (occ),
      .new_start_i  (req_start_q),
      .new_end_i    (req_end_q),
      .new_tag_i    (req_tag_q),
      .prev_link_i  (link[k]),
      .prev_start_i (c_start[k]),
      .prev_end_i   (c_end[k]),
      .prev_tag_i   (c_tag[k]),
      .link_o       (link[k+1]),
      .load_o       (load[k]),
      .start_o      (c_start[k+1]),
      .end_o        (c_end[k+1]),
      .tag_o        (c_tag[k+1])
    );

    if (k < (1 << POS_W)) begin : g_rd
      assign rd_hit = (state_q == ST_EXEC) && (func_q == FUNC_READ) && occ &&
                      (req_idx_q == POS_W'(k));
    end else begin : g_no_rd
      assign rd_hit = 1'b0;
    end

    // At most one slot drives the tree: the insertion point or the slot read.
    assign sel[k]  = load[k] || rd_hit;
    assign lane[k] = !sel[k]  ? '0 :
                     rd_hit   ? {POS_W'(k), c_start[k+1], c_end[k+1], c_tag[k+1]} :
                                {POS_W'(k), {(LW - POS_W){1'b0}}};
  end

  sit_or_tree #(
    .N (CAPACITY),
    .W (LW)
  ) u_tree (
    .clk_i  (clk_i),
    .load_i (state_q == ST_EXEC),
    .lane_i (lane),
    .sum_o  (tree_sum)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_tag_q, out_end_q, out_start_q, out_count_q, out_pos_q};

  `SIT_ASSERT(a_count_bound, (count_q <= CW'(CAPACITY)), "record count above capacity")
  `SIT_ASSERT(a_count_step, (ins_en |=> (count_q - $past(count_q) == CW'(1))), "bad count step")
  `SIT_ASSERT(a_sel_onehot, ($onehot0(sel)), "more than one slot selected")
  `SIT_ASSERT(a_out_from_red, ($rose(out_valid_q) |-> ($past(state_q) == ST_RED)), "early load")

endmodule

/* rtl/core/sit_cell.sv */
// One slot of the sorted table: holds a record, compares it against the new
// record and either keeps it, takes its lower neighbor's record or loads the new one. Uses sit_pkg.
module sit_cell #(
  parameter int TagW = 16
) (
  input  logic                            clk_i,
  input  sit_pkg::cell_ctrl_t             ctrl_i,
  input  logic                            occ_i,
  input  logic signed [63:0]              new_start_i,
  input  logic signed [63:0]              new_end_i,
  input  logic [TagW-1:0]                 new_tag_i,
  input  sit_pkg::link_t                  prev_link_i,
  input  logic signed [63:0]              prev_start_i,
  input  logic signed [63:0]              prev_end_i,
  input  logic [TagW-1:0]                 prev_tag_i,
  output sit_pkg::link_t                  link_o,
  output logic                            load_o,
  output logic signed [63:0]              start_o,
  output logic signed [63:0]              end_o,
  output logic [TagW-1:0]                 tag_o
);
  import sit_pkg::*;

  logic signed [KEY_W-1:0] start_q;
  logic signed [KEY_W-1:0] rec_end_q;
  logic [TagW-1:0]         tag_q;
  logic                    precedes;
  logic                    shift;
  logic                    load;

  assign precedes = occ_i && orders_before(new_start_i, new_end_i, start_q, rec_end_q);
  // Every occupied slot above the insertion point, and the first free slot, takes its neighbor's record.
  assign shift  = ctrl_i.ins_en && prev_link_i.precedes;
  // The insertion point is the first slot the new record precedes, or the
  // first free slot when it precedes none.
  assign load   = ctrl_i.ins_en && !prev_link_i.precedes &&
                  (precedes || (!occ_i && prev_link_i.occ));

  always_ff @(posedge clk_i) begin
    if (shift) begin
      start_q   <= prev_start_i;
      rec_end_q <= prev_end_i;
      tag_q     <= prev_tag_i;
    end else if (load) begin
      start_q   <= new_start_i;
      rec_end_q <= new_end_i;
      tag_q     <= new_tag_i;
    end
  end

  assign link_o  = '{occ: occ_i, precedes: precedes};
  assign load_o  = load;
  assign start_o = start_q;
  assign end_o   = rec_end_q;
  assign tag_o   = tag_q;

endmodule

/* rtl/core/sit_or_tree.sv */
// Two-level OR reduction of one-hot selected lanes: groups of eight are
// registered, the group results are ORed after the register. Uses sit_pkg.
module sit_or_tree #(
  parameter int N = 64,
  parameter int W = 150
) (
  input  logic                clk_i,
  input  logic                load_i,
  input  logic [N-1:0][W-1:0] lane_i,
  output logic [W-1:0]        sum_o
);
  import sit_pkg::*;

  localparam int G = (N + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [G-1:0][W-1:0] grp_d;
  logic [G-1:0][W-1:0] grp_q;

  always_comb begin
    grp_d = '0;
    for (int g = 0; g < G; g++) begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < N) begin
          grp_d[g] = grp_d[g] | lane_i[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    sum_o = '0;
    for (int g = 0; g < G; g++) begin
      sum_o = sum_o | grp_q[g];
    end
  end

endmodule
